/* hdl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, codes and sizes shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

   // heap geometry
   localparam int MAX_BLOCKS  = 4096;
   localparam int IDX_W       = 12;
   localparam int BLOCK_SHIFT = 6;
   localparam int LEN_W       = 13;
   localparam int ALU_W       = 14;
   localparam int CSR_IDX_W   = 8;

   // action codes
   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_INIT  = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NULL     = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_NOTALLOC = 3'd3;
   localparam logic [2:0] ST_NOFIT    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_START = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_END   = 8'd1;

   typedef struct packed {
      logic [1:0]  action;
      logic [12:0] alloc_blocks;
      logic [31:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] payload_addr;
   } rsp_type;

   // one segment table entry
   typedef struct packed {
      logic             head;
      logic             free;
      logic [LEN_W-1:0] len;
   } seg_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      seg_type          data;
   } tbl_wr_type;

   typedef struct packed {
      logic             sub;
      logic             cin;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

endpackage

/* hdl/ffha_alu.sv */
// ----------------------------------------------------------------------------
// ffha_alu
// Shared index/length adder: a + b + cin, or a + ~b + cin when subtracting.
// ----------------------------------------------------------------------------
module ffha_alu
   import ffha_pkg::*;
(
   input  alu_req_type      op,
   output logic [ALU_W-1:0] sum
);

   // invert the second operand for subtraction
   assign sum = op.a + (op.sub ? ~op.b : op.b) + {{(ALU_W-1){1'b0}}, op.cin};

endmodule

/* hdl/ffha_table.sv */
// ----------------------------------------------------------------------------
// ffha_table
// Segment table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_table
   import ffha_pkg::*;
(
   input  logic             clock,
   input  tbl_wr_type       wr,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output seg_type          rd_data
);

   seg_type mem [MAX_BLOCKS];
   seg_type rd_data_ff;

   // write entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read entry, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit block heap with split on allocate and neighbor merge on free.
// ----------------------------------------------------------------------------
// Initialize runs a table clearing sweep, one entry a cycle, then lays down the
// free segment. Allocate reads and tests one segment at a time; free tests the
// next neighbor, then scans backward block by block to the previous header.
// One item at a time: busy stays high until the result strobe, one word each.
// Synchronous reset clears control state; table contents stay undefined until
// the first initialize. The receiver cannot stall the result strobe.
module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req,
   output logic                 rsp_valid,
   output rsp_type              rsp,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   typedef enum logic [17:0] {
      S_IDLE     = 18'h00001,
      S_INIT_CLR = 18'h00002,
      S_INIT_W0  = 18'h00004,
      S_A_RD     = 18'h00008,
      S_A_CHK    = 18'h00010,
      S_A_KEY    = 18'h00020,
      S_A_SPLIT  = 18'h00040,
      S_A_HEAD   = 18'h00080,
      S_F_RD     = 18'h00100,
      S_F_CHK    = 18'h00200,
      S_F_NRD    = 18'h00400,
      S_F_NCHK   = 18'h00800,
      S_F_PSTART = 18'h01000,
      S_F_PRD    = 18'h02000,
      S_F_PCHK   = 18'h04000,
      S_F_PWR    = 18'h08000,
      S_F_ICLR   = 18'h10000,
      S_F_IWR    = 18'h20000
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      start_addr_ff, start_addr_in;
   logic [31:0]      end_addr_ff, end_addr_in;
   logic [31:0]      base_ff, base_in;
   logic [32:0]      init_base_ff, init_base_in;
   logic             ready_ff, ready_in;
   logic [ALU_W-1:0] idx_ff, idx_in;
   logic [ALU_W-1:0] jdx_ff, jdx_in;
   logic [ALU_W-1:0] need_ff, need_in;
   logic [LEN_W-1:0] size_ff, size_in;
   logic [LEN_W-1:0] cur_len_ff, cur_len_in;
   logic             split_ff, split_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   tbl_wr_type       wr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   seg_type          rd_data;
   alu_req_type      alu_op;
   logic [ALU_W-1:0] alu_sum;

   // free address checks
   logic [32:0]      first_payload;
   logic [32:0]      free_off;
   // initialize sizing
   logic [32:0]      end_ext;
   logic [32:0]      heap_span;
   logic [LEN_W-1:0] heap_blocks;
   logic [LEN_W-1:0] hdr_blk;

   ffha_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ffha_alu u_alu (
      .op  (alu_op),
      .sum (alu_sum)
   );

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign first_payload = {1'b0, base_ff} + 33'(1 << BLOCK_SHIFT);
   assign free_off      = {1'b0, req.free_addr} - first_payload;
   assign end_ext       = {1'b0, end_addr_ff};
   assign heap_span     = end_ext - init_base_ff;
   assign hdr_blk       = {1'b0, idx_ff[IDX_W-1:0]} + 13'd1;

   // clamp the heap's block count
   always_comb begin
      if (end_ext <= init_base_ff) begin
         heap_blocks = '0;
      end else if (|heap_span[32:BLOCK_SHIFT+IDX_W]) begin
         heap_blocks = LEN_W'(MAX_BLOCKS);
      end else begin
         heap_blocks = {1'b0, heap_span[BLOCK_SHIFT+IDX_W-1:BLOCK_SHIFT]};
      end
   end

   // select the shared adder's operands
   always_comb begin
      alu_op = '{sub: 1'b0, cin: 1'b1, a: idx_ff, b: {1'b0, rd_data.len}};
      unique case (state_ff)
         S_A_KEY:    alu_op = '{sub: 1'b0, cin: 1'b0, a: idx_ff, b: need_ff};
         S_A_SPLIT:  alu_op = '{sub: 1'b1, cin: 1'b1, a: {1'b0, cur_len_ff}, b: need_ff};
         S_F_NCHK:   alu_op = '{sub: 1'b0, cin: 1'b1, a: {1'b0, cur_len_ff},
                                b: {1'b0, rd_data.len}};
         S_F_PWR:    alu_op = '{sub: 1'b0, cin: 1'b1, a: {1'b0, cur_len_ff},
                                b: {1'b0, rd_data.len}};
         S_F_PSTART: alu_op = '{sub: 1'b1, cin: 1'b0, a: idx_ff, b: '0};
         S_F_PCHK:   alu_op = '{sub: 1'b1, cin: 1'b0, a: jdx_ff, b: '0};
         default:    alu_op = '{sub: 1'b0, cin: 1'b1, a: idx_ff, b: {1'b0, rd_data.len}};
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      start_addr_in = start_addr_ff;
      end_addr_in   = end_addr_ff;
      base_in       = base_ff;
      init_base_in  = init_base_ff;
      ready_in      = ready_ff;
      idx_in        = idx_ff;
      jdx_in        = jdx_ff;
      need_in       = need_ff;
      size_in       = size_ff;
      cur_len_in    = cur_len_ff;
      split_in      = split_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr            = '{en: 1'b0, addr: idx_ff[IDX_W-1:0], data: '0};
      rd_en         = 1'b0;
      rd_addr       = idx_ff[IDX_W-1:0];

      // take register writes
      if (csr_valid) begin
         if (csr_index == CSR_HEAP_START) begin
            start_addr_in = csr_data;
         end else if (csr_index == CSR_HEAP_END) begin
            end_addr_in = csr_data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in = '{status: ST_OK, payload_addr: '0};
               unique case (req.action)
                  ACT_ALLOC: begin
                     if (!ready_ff || req.alloc_blocks == '0) begin
                        rsp_in.status = ST_NULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        size_in  = req.alloc_blocks;
                        need_in  = {1'b0, req.alloc_blocks} + 14'd1;
                        idx_in   = '0;
                        state_in = S_A_RD;
                     end
                  end
                  ACT_FREE: begin
                     priority if (req.free_addr == '0) begin
                        rsp_in.status = ST_NULL;
                        rsp_valid_in  = 1'b1;
                     end else if (req.free_addr < start_addr_ff ||
                                  req.free_addr >= end_addr_ff) begin
                        rsp_in.status = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (!ready_ff || {1'b0, req.free_addr} < first_payload ||
                                  free_off[BLOCK_SHIFT-1:0] != '0 ||
                                  |free_off[32:BLOCK_SHIFT+IDX_W]) begin
                        rsp_in.status = ST_NOTALLOC;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        idx_in   = {2'b00, free_off[BLOCK_SHIFT+IDX_W-1:BLOCK_SHIFT]};
                        state_in = S_F_RD;
                     end
                  end
                  ACT_INIT: begin
                     init_base_in = ({1'b0, start_addr_ff} + 33'((1 << BLOCK_SHIFT) - 1)) &
                                    ~33'((1 << BLOCK_SHIFT) - 1);
                     idx_in       = '0;
                     state_in     = S_INIT_CLR;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // clear heads and free marks, one entry a cycle
         S_INIT_CLR: begin
            wr = '{en: 1'b1, addr: idx_ff[IDX_W-1:0], data: '0};
            idx_in = idx_ff + 14'd1;
            if (idx_ff[IDX_W-1:0] == IDX_W'(MAX_BLOCKS - 1)) begin
               state_in = S_INIT_W0;
            end
         end

         // lay down the single free segment
         S_INIT_W0: begin
            base_in  = init_base_ff[31:0];
            ready_in = 1'b1;
            if (heap_blocks != '0) begin
               wr = '{en: 1'b1, addr: '0,
                      data: '{head: 1'b1, free: 1'b1, len: heap_blocks - 13'd1}};
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_A_RD: begin
            rd_en    = 1'b1;
            state_in = S_A_CHK;
         end

         // test the segment, or step to the next one
         S_A_CHK: begin
            if (!rd_data.head) begin
               rsp_in.status = ST_NOFIT;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (rd_data.free && {1'b0, rd_data.len} >= need_ff) begin
               cur_len_in = rd_data.len;
               split_in   = ({1'b0, rd_data.len} > need_ff);
               state_in   = ({1'b0, rd_data.len} > need_ff) ? S_A_KEY : S_A_HEAD;
            end else begin
               idx_in = alu_sum;
               if (alu_sum >= ALU_W'(MAX_BLOCKS)) begin
                  rsp_in.status = ST_NOFIT;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_A_RD;
               end
            end
         end

         S_A_KEY: begin
            jdx_in   = alu_sum;
            state_in = S_A_SPLIT;
         end

         // write the remainder segment
         S_A_SPLIT: begin
            if (jdx_ff < ALU_W'(MAX_BLOCKS)) begin
               wr = '{en: 1'b1, addr: jdx_ff[IDX_W-1:0],
                      data: '{head: 1'b1, free: 1'b1, len: alu_sum[LEN_W-1:0]}};
            end
            state_in = S_A_HEAD;
         end

         S_A_HEAD: begin
            wr = '{en: 1'b1, addr: idx_ff[IDX_W-1:0],
                   data: '{head: 1'b1, free: 1'b0, len: split_ff ? size_ff : cur_len_ff}};
            rsp_in.payload_addr = base_ff + {13'd0, hdr_blk, 6'd0};
            rsp_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end

         S_F_RD: begin
            rd_en    = 1'b1;
            state_in = S_F_CHK;
         end

         S_F_CHK: begin
            if (!rd_data.head || rd_data.free) begin
               rsp_in.status = ST_NOTALLOC;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cur_len_in = rd_data.len;
               jdx_in     = alu_sum;
               state_in   = (alu_sum < ALU_W'(MAX_BLOCKS)) ? S_F_NRD : S_F_PSTART;
            end
         end

         S_F_NRD: begin
            rd_en    = 1'b1;
            rd_addr  = jdx_ff[IDX_W-1:0];
            state_in = S_F_NCHK;
         end

         // absorb a free next neighbor
         S_F_NCHK: begin
            if (rd_data.head && rd_data.free) begin
               cur_len_in = alu_sum[LEN_W-1:0];
               wr         = '{en: 1'b1, addr: jdx_ff[IDX_W-1:0], data: '0};
            end
            state_in = S_F_PSTART;
         end

         S_F_PSTART: begin
            jdx_in   = alu_sum;
            state_in = (idx_ff == '0) ? S_F_IWR : S_F_PRD;
         end

         S_F_PRD: begin
            rd_en    = 1'b1;
            rd_addr  = jdx_ff[IDX_W-1:0];
            state_in = S_F_PCHK;
         end

         // scan backward for the previous header
         S_F_PCHK: begin
            if (rd_data.head) begin
               state_in = rd_data.free ? S_F_PWR : S_F_IWR;
            end else if (jdx_ff == '0) begin
               state_in = S_F_IWR;
            end else begin
               jdx_in   = alu_sum;
               state_in = S_F_PRD;
            end
         end

         // grow the previous free segment over this one
         S_F_PWR: begin
            wr = '{en: 1'b1, addr: jdx_ff[IDX_W-1:0],
                   data: '{head: 1'b1, free: 1'b1, len: alu_sum[LEN_W-1:0]}};
            state_in = S_F_ICLR;
         end

         S_F_ICLR: begin
            wr           = '{en: 1'b1, addr: idx_ff[IDX_W-1:0], data: '0};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_F_IWR: begin
            wr = '{en: 1'b1, addr: idx_ff[IDX_W-1:0],
                   data: '{head: 1'b1, free: 1'b1, len: cur_len_ff}};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         start_addr_ff <= '0;
         end_addr_ff   <= 32'd262144;
         base_ff       <= '0;
         ready_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_addr_ff <= start_addr_in;
         end_addr_ff   <= end_addr_in;
         base_ff       <= base_in;
         ready_ff      <= ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      init_base_ff <= init_base_in;
      idx_ff       <= idx_in;
      jdx_ff       <= jdx_in;
      need_ff      <= need_in;
      size_ff      <= size_in;
      cur_len_ff   <= cur_len_in;
      split_ff     <= split_in;
      rsp_ff       <= rsp_in;
   end

   // an accepted initialize word always raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req.action == ACT_INIT |=> busy)
      else $error("initialize did not start the clearing sweep");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != ST_OK |-> rsp.payload_addr == '0)
      else $error("nonzero address on a failed request");

   a_end_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("work finished without a result");

endmodule

/* tb/tb_first_fit_heap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Drives the allocator with directed allocate, free and init words and random
// allocate and free words under several heap windows, predicts each status word in-bench and
// compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
   import ffha_pkg::*;

   localparam int BLK = 64;

   typedef struct {
      req_type word;
      bit      pick_live;
   } cmd_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req = '0;
   logic                 rsp_valid;
   rsp_type              rsp;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   // heap shadow state
   bit          seg_head [MAX_BLOCKS];
   bit          seg_open [MAX_BLOCKS];
   int unsigned seg_len  [MAX_BLOCKS];
   logic [31:0] base_addr = '0;
   bit          heap_up = 1'b0;
   logic [31:0] win_start = 32'd0;
   logic [31:0] win_end = 32'd262144;

   cmd_type     pending_cmds[$];
   rsp_type     expected_rsps[$];
   logic [31:0] live_addrs[$];
   int          mismatches = 0;
   bit          taken = 1'b0;
   bit          quiet = 1'b0;
   int          idle_left = 0;

   first_fit_heap_allocator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // rebuild the heap as one free segment
   function void heap_setup();
      longint unsigned b, e, nb;
      b = ((longint'(win_start) + BLK - 1) / BLK) * BLK;
      e = win_end;
      nb = 0;
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         seg_head[k] = 0;
         seg_open[k] = 0;
      end
      base_addr = b[31:0];
      if (e > b) nb = (e - b) / BLK;
      if (nb > MAX_BLOCKS) nb = MAX_BLOCKS;
      if (nb >= 1) begin
         seg_head[0] = 1;
         seg_open[0] = 1;
         seg_len[0] = 32'(nb - 1);
      end
      heap_up = 1;
      live_addrs.delete();
   endfunction

   // first fit walk with split
   function logic [2:0] heap_take(int unsigned size, output logic [31:0] addr);
      int unsigned need, i, k;
      longint unsigned a;
      need = size + 1;
      i = 0;
      addr = '0;
      if (!heap_up || size == 0) return ST_NULL;
      while (i < MAX_BLOCKS && seg_head[i]) begin
         if (seg_open[i] && seg_len[i] >= need) begin
            if (seg_len[i] > need) begin
               k = i + need;
               if (k < MAX_BLOCKS) begin
                  seg_head[k] = 1;
                  seg_open[k] = 1;
                  seg_len[k] = seg_len[i] - need;
               end
               seg_len[i] = size;
            end
            seg_open[i] = 0;
            a = longint'(base_addr) + longint'(i + 1) * BLK;
            addr = a[31:0];
            return ST_OK;
         end
         i += 1 + seg_len[i];
      end
      return ST_NOFIT;
   endfunction

   // release with merge of both neighbors
   function logic [2:0] heap_give(logic [31:0] addr);
      longint unsigned first, off;
      int unsigned i, j;
      if (addr == 0) return ST_NULL;
      if (addr < win_start || addr >= win_end) return ST_RANGE;
      first = longint'(base_addr) + BLK;
      if (!heap_up || longint'(addr) < first) return ST_NOTALLOC;
      off = longint'(addr) - first;
      if (off % BLK != 0) return ST_NOTALLOC;
      off = off / BLK;
      if (off >= MAX_BLOCKS) return ST_NOTALLOC;
      i = 32'(off);
      if (!seg_head[i] || seg_open[i]) return ST_NOTALLOC;
      seg_open[i] = 1;
      j = i + 1 + seg_len[i];
      if (j < MAX_BLOCKS && seg_head[j] && seg_open[j]) begin
         seg_len[i] += 1 + seg_len[j];
         seg_head[j] = 0;
         seg_open[j] = 0;
      end
      j = i;
      while (j > 0) begin
         j--;
         if (seg_head[j]) begin
            if (seg_open[j]) begin
               seg_len[j] += 1 + seg_len[i];
               seg_head[i] = 0;
               seg_open[i] = 0;
            end
            break;
         end
      end
      return ST_OK;
   endfunction

   function rsp_type predict_rsp(req_type w);
      rsp_type e;
      e = '0;
      case (w.action)
         ACT_ALLOC: begin
            e.status = heap_take(32'(w.alloc_blocks), e.payload_addr);
            if (e.status == ST_OK) live_addrs.push_back(e.payload_addr);
         end
         ACT_FREE: e.status = heap_give(w.free_addr);
         ACT_INIT: heap_setup();
         default: e.status = ST_OK;
      endcase
      return e;
   endfunction

   // check results first, then predict the word accepted at this edge
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: status %0d addr %h", rsp.status,
                           rsp.payload_addr);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp.status !== e.status || rsp.payload_addr !== e.payload_addr) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: status exp %0d got %0d, addr exp %h got %h",
                              e.status, rsp.status, e.payload_addr, rsp.payload_addr);
               end
            end
         end
         if (start && !busy) begin
            expected_rsps.push_back(predict_rsp(req));
            taken = 1;
         end
      end
   end

   // feed words from the pending queue with random idle bursts
   always @(negedge clock) begin
      cmd_type c;
      int      n;
      logic    next_start;
      if (!reset) begin
         next_start = start;
         if (!start || taken) begin
            taken = 0;
            next_start = 1'b0;
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_cmds.size() > 0) begin
               if (!quiet && $urandom_range(0, 9) == 0) begin
                  idle_left = $urandom_range(1, 18);
               end else begin
                  c = pending_cmds.pop_front();
                  if (c.pick_live) begin
                     if (live_addrs.size() > 0) begin
                        n = $urandom_range(0, live_addrs.size() - 1);
                        c.word.free_addr = live_addrs[n];
                        live_addrs.delete(n);
                     end else begin
                        c.word.free_addr = base_addr + BLK * $urandom_range(1, 20);
                     end
                  end
                  req <= c.word;
                  next_start = 1'b1;
               end
            end
         end
         start <= next_start;
      end
   end

   task automatic push_cmd(logic [1:0] act, logic [12:0] blocks, logic [31:0] addr,
                           bit live = 0);
      cmd_type c;
      c.word.action = act;
      c.word.alloc_blocks = blocks;
      c.word.free_addr = addr;
      c.pick_live = live;
      pending_cmds.push_back(c);
   endtask

   // hold until every word is answered and the block is quiet
   task automatic drain();
      while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || start || busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_HEAP_START) win_start = value;
      else if (idx == CSR_HEAP_END) win_end = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_cmds(int count, int max_big);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            push_cmd(ACT_ALLOC, 13'($urandom_range(1, 8)), '0);
         else if (r < 47)
            push_cmd(ACT_ALLOC, 13'($urandom_range(9, max_big)), '0);
         else if (r < 85)
            push_cmd(ACT_FREE, '0, '0, 1);
         else if (r < 90)
            push_cmd(ACT_FREE, '0, base_addr + 32'($urandom_range(0, 1200)));
         else if (r < 94)
            push_cmd(ACT_FREE, 13'($urandom()), $urandom());
         else if (r < 97)
            push_cmd(ACT_ALLOC, 13'($urandom()), $urandom());
         else
            push_cmd(2'd3, 13'($urandom()), $urandom());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // before any init: null, not allocated and the unused action
      push_cmd(ACT_ALLOC, 13'd5, '0);
      push_cmd(ACT_FREE, '0, 32'd0);
      push_cmd(ACT_FREE, '0, 32'd128);
      push_cmd(2'd3, 13'h1FFF, 32'hFFFF_FFFF);
      drain();

      // unaligned start, small heap of about 40 blocks
      write_reg(CSR_HEAP_START, 32'h0000_1025);
      write_reg(CSR_HEAP_END, 32'h0000_1025 + 40 * BLK);
      push_cmd(ACT_INIT, '0, '0);
      push_cmd(ACT_ALLOC, 13'd0, '0);
      push_cmd(ACT_ALLOC, 13'd1, '0);
      push_cmd(ACT_ALLOC, 13'd3, '0);
      push_cmd(ACT_ALLOC, 13'd2, '0);
      push_cmd(ACT_ALLOC, 13'h1FFF, '0);
      push_cmd(ACT_ALLOC, 13'd4096, '0);
      push_cmd(ACT_FREE, '0, 32'h0000_1080 + 2 * BLK);
      push_cmd(ACT_FREE, '0, 32'h0000_1080 + 2 * BLK);
      push_cmd(ACT_FREE, '0, 32'h0000_1081);
      push_cmd(ACT_FREE, '0, 32'h0000_1040);
      push_cmd(ACT_FREE, '0, 32'hFFFF_FFFF);
      push_cmd(ACT_ALLOC, 13'd2, '0);
      push_cmd(ACT_FREE, '0, '0, 1);
      push_cmd(ACT_FREE, '0, '0, 1);
      push_cmd(ACT_ALLOC, 13'd32, '0);
      drain();

      // start wraps past the top when aligned: empty heap
      write_reg(CSR_HEAP_START, 32'hFFFF_FFC1);
      write_reg(CSR_HEAP_END, 32'hFFFF_FFFF);
      push_cmd(ACT_INIT, '0, '0);
      push_cmd(ACT_ALLOC, 13'd1, '0);
      push_cmd(ACT_FREE, '0, 32'hFFFF_FFC1);
      drain();

      // single block heap: header only
      write_reg(CSR_HEAP_START, 32'h0000_0200);
      write_reg(CSR_HEAP_END, 32'h0000_0240);
      push_cmd(ACT_INIT, '0, '0);
      push_cmd(ACT_ALLOC, 13'd1, '0);
      push_cmd(ACT_FREE, '0, 32'h0000_0200);
      drain();

      // medium heap, mostly well-formed traffic
      write_reg(CSR_HEAP_START, 32'h0000_1003);
      write_reg(CSR_HEAP_END, 32'h0000_1003 + 300 * BLK);
      push_cmd(ACT_INIT, '0, '0);
      drain();
      random_cmds(40, 60);
      drain();

      // full range, clamped to the table size; calm tail
      write_reg(CSR_HEAP_START, 32'h0000_0000);
      write_reg(CSR_HEAP_END, 32'hFFFF_FFFF);
      push_cmd(ACT_INIT, '0, '0);
      push_cmd(ACT_ALLOC, 13'd4095, '0);
      push_cmd(ACT_FREE, '0, 32'd64);
      drain();
      random_cmds(50, 400);
      drain();
      quiet = 1;
      random_cmds(20, 30);
      drain();
      repeat (20) @(posedge clock);

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* sim.f */
hdl/ffha_pkg.sv
hdl/ffha_alu.sv
hdl/ffha_table.sv
hdl/first_fit_heap_allocator.sv
tb/tb_first_fit_heap_allocator.sv
